@@ rtl/pps_pkg.sv @@
`timescale 1ns / 1ps
// pps_pkg: shared widths, item kind and status codes of the physical page free stack
// no dependencies

package pps_pkg;

  localparam int ADDR_W    = 28;  // byte address fields
  localparam int LEN_W     = 29;  // region length field
  localparam int SUM_W     = 30;  // base + length without overflow
  localparam int SPAN_W    = 22;  // page numbers of a region span, smallest page size
  localparam int OUT_CNT_W = 17;  // pages_added and free_count fields
  localparam int TOTAL_W   = 32;  // total_memory field
  localparam int STATUS_W  = 2;

  localparam logic [ADDR_W-1:0] KERNEL_END_RST = 28'd1048576;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2
  } kind_t;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

  // page span of one region: pages first .. last_excl-1
  typedef struct packed {
    logic [SPAN_W-1:0] first;
    logic [SPAN_W-1:0] last_excl;
  } span_t;

endpackage

@@ rtl/pps_link_mem.sv @@
`timescale 1ns / 1ps
// pps_link_mem: next-link store, one write port and one registered read port
// no dependencies

module pps_link_mem #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 16,
  parameter int IDX_W  = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pps_region_span.sv @@
`timescale 1ns / 1ps
// pps_region_span: page span of a memory region clamped to kernel end and memory size
// depends on pps_pkg

module pps_region_span
  import pps_pkg::*;
#(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic [ADDR_W-1:0] base,
  input  logic [LEN_W-1:0]  length,
  input  logic [ADDR_W-1:0] kernel_end,
  output span_t             span
);

  localparam int PG_SH = $clog2(PAGE_BYTES);

  logic [ADDR_W-1:0] start;
  logic [SUM_W-1:0]  start_up;
  logic [SUM_W-1:0]  end_sum;
  logic [SPAN_W-1:0] first_pg;
  logic [SPAN_W-1:0] end_pg;

  always_comb begin
    start    = (base < kernel_end) ? kernel_end : base;
    start_up = SUM_W'(start) + SUM_W'(PAGE_BYTES - 1);
    end_sum  = SUM_W'(base) + SUM_W'(length);
    first_pg = SPAN_W'(start_up >> PG_SH);
    end_pg   = SPAN_W'(end_sum >> PG_SH);
    if (end_pg > SPAN_W'(PAGE_COUNT)) begin
      end_pg = SPAN_W'(PAGE_COUNT);
    end
    // page zero marks an empty stack and is never pushed
    if (first_pg == '0) begin
      first_pg = SPAN_W'(1);
    end
    span.first     = first_pg;
    span.last_excl = end_pg;
  end

endmodule

@@ rtl/physical_page_free_stack.sv @@
`timescale 1ns / 1ps
// physical_page_free_stack: top level, control sequencer and result register
// depends on pps_pkg, pps_link_mem, pps_region_span
//
// Free stack of physical pages kept as a linked list in a next-link memory.
// Input channel (in_valid / in_stall) carries one item per transfer: add a
// memory region, allocate a page or free a page. Every item gives exactly one
// result on the output channel (out_valid / out_stall), held in an output
// register until transferred. The cfg channel writes kernel_end; cfg_ready
// is always high and writes belong in idle periods.
// Free, unknown kind, unavailable region and allocate on an empty stack are
// answered from idle; allocate waits in ST_ALLOC for the registered read of
// the next link; an available region runs ST_SETUP and ST_LOAD, one link
// write per page. One item is in work at a time; a new item is taken once
// the sequencer is idle and the output register is empty or transfers in
// that cycle; a stalled receiver holds input off after one waiting result.
// Reset empties the stack, clears counts and total memory and sets
// kernel_end to 1 MiB; the link memory needs no clearing.
// The input channel is stalled while reset is held.

module physical_page_free_stack
  import pps_pkg::*;
#(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [ADDR_W-1:0]    in_region_base,
  input  logic [LEN_W-1:0]     in_region_length,
  input  logic                 in_region_available,
  input  logic [ADDR_W-1:0]    in_freed_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    out_page_address,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_CNT_W-1:0] out_pages_added,
  output logic [OUT_CNT_W-1:0] out_free_count,
  output logic [TOTAL_W-1:0]   out_total_memory,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ADDR_W-1:0]    cfg_kernel_end
);

  localparam int PW    = $clog2(PAGE_COUNT);
  localparam int CNT_W = $clog2(PAGE_COUNT + 1);
  localparam int PG_SH = $clog2(PAGE_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD,
    ST_ALLOC
  } state_t;

  state_t               state_r;
  logic [PW-1:0]        top_r;
  logic [CNT_W-1:0]     free_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [ADDR_W-1:0]    kernel_end_r;
  logic [ADDR_W-1:0]    base_r;
  logic [LEN_W-1:0]     len_r;
  logic [SPAN_W-1:0]    cur_r;
  logic [SPAN_W-1:0]    end_r;
  logic [CNT_W-1:0]     added_r;

  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_page_address_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [OUT_CNT_W-1:0] out_pages_added_r;
  logic [OUT_CNT_W-1:0] out_free_count_r;

  logic                 accept;
  logic [ADDR_W-1:0]    freed_page;
  logic                 free_ok;
  logic                 load_more;
  logic [CNT_W-1:0]     free_inc;
  logic [CNT_W-1:0]     free_dec;
  logic [TOTAL_W:0]     total_sum;
  logic [TOTAL_W-1:0]   total_nxt;
  logic                 mem_we;
  logic [PW-1:0]        mem_waddr;
  logic [PW-1:0]        mem_rdata;
  span_t                span;

  pps_link_mem #(
    .DEPTH  (PAGE_COUNT),
    .DATA_W (PW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (top_r),
    .raddr (top_r),
    .rdata (mem_rdata)
  );

  pps_region_span #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_region_span (
    .base       (base_r),
    .length     (len_r),
    .kernel_end (kernel_end_r),
    .span       (span)
  );

  always_comb begin
    in_stall   = !rst_n || !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));
    accept     = in_valid && !in_stall;
    freed_page = in_freed_address >> PG_SH;
    free_ok    = (freed_page != '0) && (freed_page < ADDR_W'(PAGE_COUNT));
    load_more  = (cur_r < end_r);
    free_inc   = (free_r == CNT_W'(PAGE_COUNT)) ? free_r : free_r + 1'b1;
    free_dec   = (free_r == '0) ? free_r : free_r - 1'b1;
    total_sum  = {1'b0, total_r} + (TOTAL_W + 1)'(len_r);
    total_nxt  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    mem_we     = (accept && (in_kind == KIND_FREE) && free_ok) ||
                 ((state_r == ST_LOAD) && load_more);
    mem_waddr  = (state_r == ST_LOAD) ? cur_r[PW-1:0] : freed_page[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      top_r        <= '0;
      free_r       <= '0;
      total_r      <= '0;
      kernel_end_r <= KERNEL_END_RST;
    end else begin
      if (cfg_valid) begin
        kernel_end_r <= cfg_kernel_end;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            out_page_address_r <= '0;
            out_status_r       <= STATUS_OK;
            out_pages_added_r  <= '0;
            out_free_count_r   <= OUT_CNT_W'(free_r);
            unique case (in_kind)
              KIND_ADD: begin
                if (in_region_available) begin
                  base_r  <= in_region_base;
                  len_r   <= in_region_length;
                  state_r <= ST_SETUP;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              KIND_ALLOC: begin
                // link of the top page is read at this edge
                if (top_r == '0) begin
                  out_status_r <= STATUS_EMPTY;
                  out_valid_r  <= 1'b1;
                end else begin
                  state_r <= ST_ALLOC;
                end
              end
              KIND_FREE: begin
                if (free_ok) begin
                  top_r            <= freed_page[PW-1:0];
                  free_r           <= free_inc;
                  out_free_count_r <= OUT_CNT_W'(free_inc);
                end else begin
                  out_status_r <= STATUS_REJECT;
                end
                out_valid_r <= 1'b1;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_SETUP: begin
          total_r <= total_nxt;
          cur_r   <= span.first;
          end_r   <= span.last_excl;
          added_r <= '0;
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (load_more) begin
            // push one page per cycle in ascending order
            top_r   <= cur_r[PW-1:0];
            free_r  <= free_inc;
            cur_r   <= cur_r + 1'b1;
            added_r <= added_r + 1'b1;
          end else begin
            out_pages_added_r <= OUT_CNT_W'(added_r);
            out_free_count_r  <= OUT_CNT_W'(free_r);
            out_valid_r       <= 1'b1;
            state_r           <= ST_IDLE;
          end
        end
        ST_ALLOC: begin
          top_r              <= mem_rdata;
          free_r             <= free_dec;
          out_page_address_r <= ADDR_W'({top_r, {PG_SH{1'b0}}});
          out_free_count_r   <= OUT_CNT_W'(free_dec);
          out_valid_r        <= 1'b1;
          state_r            <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_page_address = out_page_address_r;
  assign out_status       = out_status_r;
  assign out_pages_added  = out_pages_added_r;
  assign out_free_count   = out_free_count_r;
  assign out_total_memory = total_r;

endmodule
